>>> rtl/asc_pkg.sv
`default_nettype none

package asc_pkg;

  localparam int VALUE_WIDTH = 16;
  localparam int LIMIT_WIDTH = 16;
  localparam int COUNT_WIDTH = 7;
  localparam int SUM_OUT_WIDTH = 18;

  // The second pass runs on a partner value that is bounded by the limit, so the
  // working width covers both the input and the limit.
  localparam int WORK_WIDTH = (VALUE_WIDTH > LIMIT_WIDTH) ? VALUE_WIDTH : LIMIT_WIDTH;
  localparam int ROOT_WIDTH = WORK_WIDTH / 2 + 1;
  localparam int SQ_WIDTH = WORK_WIDTH + 1;
  localparam int CNT_ACC_WIDTH = ROOT_WIDTH + 1;
  localparam int SUM_ACC_WIDTH = WORK_WIDTH + 3;
  localparam int DIV_CNT_WIDTH = $clog2(WORK_WIDTH + 1);

  localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = '1;

  localparam int STEP_WIDTH = 4;
  typedef logic [STEP_WIDTH-1:0] step_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_INIT,
    OP_DIV_START,
    OP_ACCUM,
    OP_END_PASS,
    OP_INIT2,
    OP_PUBLISH
  } op_t;

  typedef enum logic [3:0] {
    C_NEXT,
    C_JUMP,
    C_WAIT_IN,
    C_N_ZERO,
    C_DSQ_GT_N,
    C_DIV_BUSY,
    C_PASS2,
    C_SKIP2,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ucode_t;

  typedef struct packed {
    logic n_zero;
    logic dsq_gt_n;
    logic div_busy;
    logic pass2;
    logic skip2;
  } dp_status_t;

  localparam step_t S_IDLE     = step_t'(0);
  localparam step_t S_INIT     = step_t'(1);
  localparam step_t S_CHECK    = step_t'(2);
  localparam step_t S_DIV      = step_t'(3);
  localparam step_t S_DWAIT    = step_t'(4);
  localparam step_t S_ACC      = step_t'(5);
  localparam step_t S_END      = step_t'(6);
  localparam step_t S_PASS2    = step_t'(7);
  localparam step_t S_LOOP     = step_t'(8);
  localparam step_t S_WAIT_OUT = step_t'(9);
  localparam step_t S_PUB      = step_t'(10);

  // Control store. A condition that holds sends the step counter to the
  // target; otherwise it moves on to the next step.
  function automatic ucode_t ucode(step_t step);
    ucode_t w;
    w = '{op: OP_NOP, cond: C_JUMP, target: S_IDLE};
    case (step)
      S_IDLE:     w = '{op: OP_NOP,       cond: C_WAIT_IN,  target: S_IDLE};
      S_INIT:     w = '{op: OP_INIT,      cond: C_N_ZERO,   target: S_WAIT_OUT};
      S_CHECK:    w = '{op: OP_NOP,       cond: C_DSQ_GT_N, target: S_END};
      S_DIV:      w = '{op: OP_DIV_START, cond: C_NEXT,     target: S_IDLE};
      S_DWAIT:    w = '{op: OP_NOP,       cond: C_DIV_BUSY, target: S_DWAIT};
      S_ACC:      w = '{op: OP_ACCUM,     cond: C_JUMP,     target: S_CHECK};
      S_END:      w = '{op: OP_END_PASS,  cond: C_PASS2,    target: S_WAIT_OUT};
      S_PASS2:    w = '{op: OP_INIT2,     cond: C_SKIP2,    target: S_WAIT_OUT};
      S_LOOP:     w = '{op: OP_NOP,       cond: C_JUMP,     target: S_CHECK};
      S_WAIT_OUT: w = '{op: OP_NOP,       cond: C_OUT_BUSY, target: S_WAIT_OUT};
      S_PUB:      w = '{op: OP_PUBLISH,   cond: C_JUMP,     target: S_IDLE};
      default:    w = '{op: OP_NOP,       cond: C_JUMP,     target: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> rtl/asc_divider.sv
`default_nettype none

module asc_divider (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic [asc_pkg::WORK_WIDTH-1:0]   dividend,
  input  wire logic [asc_pkg::ROOT_WIDTH-1:0]   divisor,
  output logic                                  busy,
  output logic [asc_pkg::WORK_WIDTH-1:0]        quotient,
  output logic [asc_pkg::ROOT_WIDTH-1:0]        remainder
);

  logic                                busy_r;
  logic [asc_pkg::DIV_CNT_WIDTH-1:0]   cnt_r;
  logic [asc_pkg::WORK_WIDTH-1:0]      quot_r;
  logic [asc_pkg::ROOT_WIDTH-1:0]      rem_r;
  logic [asc_pkg::ROOT_WIDTH-1:0]      div_r;

  logic [asc_pkg::ROOT_WIDTH:0]        trial;
  logic [asc_pkg::ROOT_WIDTH:0]        diff;
  logic                                ge;
  logic [asc_pkg::ROOT_WIDTH-1:0]      rem_nxt;

  // One restoring step per cycle: shift in the next dividend bit, subtract
  // when the partial remainder reaches the divisor.
  always_comb begin
    trial   = {rem_r, quot_r[asc_pkg::WORK_WIDTH-1]};
    diff    = trial - {1'b0, div_r};
    ge      = (trial >= {1'b0, div_r});
    rem_nxt = ge ? diff[asc_pkg::ROOT_WIDTH-1:0] : trial[asc_pkg::ROOT_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= asc_pkg::DIV_CNT_WIDTH'(asc_pkg::WORK_WIDTH);
    end else if (busy_r) begin
      cnt_r <= cnt_r - asc_pkg::DIV_CNT_WIDTH'(1);
      if (cnt_r == asc_pkg::DIV_CNT_WIDTH'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= dividend;
      rem_r  <= '0;
      div_r  <= divisor;
    end else if (busy_r) begin
      quot_r <= {quot_r[asc_pkg::WORK_WIDTH-2:0], ge};
      rem_r  <= rem_nxt;
    end
  end

  assign busy      = busy_r;
  assign quotient  = quot_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

>>> rtl/asc_datapath.sv
`default_nettype none

module asc_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                load_en,
  input  wire logic [asc_pkg::VALUE_WIDTH-1:0]     in_value,
  input  wire logic [asc_pkg::LIMIT_WIDTH-1:0]     upper_limit,
  input  wire asc_pkg::op_t                        op,
  output asc_pkg::dp_status_t                      status,
  output logic [asc_pkg::COUNT_WIDTH-1:0]          divisor_count,
  output logic [asc_pkg::SUM_OUT_WIDTH-1:0]        divisor_sum,
  output logic                                     is_perfect,
  output logic                                     is_amicable
);

  localparam int WW = asc_pkg::WORK_WIDTH;
  localparam int RW = asc_pkg::ROOT_WIDTH;
  localparam int SW = asc_pkg::SUM_ACC_WIDTH;
  localparam int CW = asc_pkg::CNT_ACC_WIDTH;
  localparam int QW = asc_pkg::SQ_WIDTH;

  logic [asc_pkg::VALUE_WIDTH-1:0]   v_r;
  logic [WW-1:0]                     n_r, n_nxt;
  logic [RW-1:0]                     d_r, d_nxt;
  logic [QW-1:0]                     dsq_r, dsq_nxt;
  logic [CW-1:0]                     c_r, c_nxt;
  logic [SW-1:0]                     s_r, s_nxt;
  logic                              pass_r, pass_nxt;
  logic [asc_pkg::COUNT_WIDTH-1:0]   cnt_o_r, cnt_o_nxt;
  logic [SW-1:0]                     sum1_r, sum1_nxt;
  logic                              perf_r, perf_nxt;
  logic                              amic_r, amic_nxt;

  logic                              div_start;
  logic                              div_busy;
  logic [WW-1:0]                     quot;
  logic [RW-1:0]                     rem;

  logic [SW-1:0]                     v_ext;
  logic [SW-1:0]                     pass_sum;
  logic [CW-1:0]                     c_dec;
  logic                              q_ne_d;

  asc_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (n_r),
    .divisor   (d_r),
    .busy      (div_busy),
    .quotient  (quot),
    .remainder (rem)
  );

  always_comb begin
    v_ext     = SW'(v_r);
    pass_sum  = s_r - SW'(n_r);
    c_dec     = c_r - CW'(1);
    q_ne_d    = (quot != WW'(d_r));
    div_start = (op == asc_pkg::OP_DIV_START);
  end

  always_comb begin
    n_nxt     = n_r;
    d_nxt     = d_r;
    dsq_nxt   = dsq_r;
    c_nxt     = c_r;
    s_nxt     = s_r;
    pass_nxt  = pass_r;
    cnt_o_nxt = cnt_o_r;
    sum1_nxt  = sum1_r;
    perf_nxt  = perf_r;
    amic_nxt  = amic_r;
    case (op)
      asc_pkg::OP_INIT: begin
        n_nxt     = WW'(v_r);
        d_nxt     = RW'(1);
        dsq_nxt   = QW'(1);
        c_nxt     = '0;
        s_nxt     = '0;
        pass_nxt  = 1'b0;
        cnt_o_nxt = '0;
        sum1_nxt  = '0;
        perf_nxt  = 1'b0;
        amic_nxt  = 1'b0;
      end
      asc_pkg::OP_ACCUM: begin
        if (rem == '0) begin
          if (q_ne_d) begin
            c_nxt = c_r + CW'(2);
            s_nxt = s_r + SW'(d_r) + SW'(quot);
          end else begin
            c_nxt = c_r + CW'(1);
            s_nxt = s_r + SW'(d_r);
          end
        end
        // (d+1)^2 = d^2 + 2d + 1 keeps the bound check free of a multiplier.
        dsq_nxt = dsq_r + QW'({d_r, 1'b1});
        d_nxt   = d_r + RW'(1);
      end
      asc_pkg::OP_END_PASS: begin
        if (pass_r) begin
          amic_nxt = (pass_sum == v_ext);
        end else begin
          cnt_o_nxt = c_dec[asc_pkg::COUNT_WIDTH-1:0];
          sum1_nxt  = pass_sum;
          perf_nxt  = (pass_sum == v_ext);
        end
      end
      asc_pkg::OP_INIT2: begin
        n_nxt    = sum1_r[WW-1:0];
        d_nxt    = RW'(1);
        dsq_nxt  = QW'(1);
        c_nxt    = '0;
        s_nxt    = '0;
        pass_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass_r <= 1'b0;
    end else begin
      pass_r <= pass_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      v_r <= in_value;
    end
    n_r     <= n_nxt;
    d_r     <= d_nxt;
    dsq_r   <= dsq_nxt;
    c_r     <= c_nxt;
    s_r     <= s_nxt;
    cnt_o_r <= cnt_o_nxt;
    sum1_r  <= sum1_nxt;
    perf_r  <= perf_nxt;
    amic_r  <= amic_nxt;
  end

  // A partner of zero only comes from a value of one and never matches.
  always_comb begin
    status.n_zero   = (v_r == '0);
    status.dsq_gt_n = (dsq_r > QW'(n_r));
    status.div_busy = div_busy;
    status.pass2    = pass_r;
    status.skip2    = (sum1_r > SW'(upper_limit)) || (sum1_r == v_ext) || (sum1_r == '0);
  end

  assign divisor_count = cnt_o_r;
  assign divisor_sum   = sum1_r[asc_pkg::SUM_OUT_WIDTH-1:0];
  assign is_perfect    = perf_r;
  assign is_amicable   = amic_r;

endmodule

`default_nettype wire

>>> rtl/asc_sequencer.sv
`default_nettype none

module asc_sequencer (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 out_busy,
  input  wire asc_pkg::dp_status_t  status,
  output asc_pkg::op_t              op,
  output logic                      idle
);

  asc_pkg::step_t  pc_r, pc_nxt;
  asc_pkg::ucode_t uw;
  logic            take;

  assign uw = asc_pkg::ucode(pc_r);

  always_comb begin
    case (uw.cond)
      asc_pkg::C_NEXT:     take = 1'b0;
      asc_pkg::C_JUMP:     take = 1'b1;
      asc_pkg::C_WAIT_IN:  take = !in_valid;
      asc_pkg::C_N_ZERO:   take = status.n_zero;
      asc_pkg::C_DSQ_GT_N: take = status.dsq_gt_n;
      asc_pkg::C_DIV_BUSY: take = status.div_busy;
      asc_pkg::C_PASS2:    take = status.pass2;
      asc_pkg::C_SKIP2:    take = status.skip2;
      asc_pkg::C_OUT_BUSY: take = out_busy;
      default:             take = 1'b1;
    endcase
    pc_nxt = take ? uw.target : pc_r + asc_pkg::step_t'(1);
  end

  always_comb begin
    op   = uw.op;
    idle = (pc_r == asc_pkg::S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= asc_pkg::S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/aliquot_sum_classifier.sv
// From the accepting edge to out_valid, the sequencer tries every divisor d with d*d <= value,
// then runs the same loop on the partner unless the partner pass is left out; each trial
// divisor runs the bound check, a divider start, a wait for the divider and an accumulate step.
// Throughput: one request at a time; in_ready returns the cycle after publish, and a result
// still waiting in the output register holds the sequencer before it publishes the next one.
// Synchronous active-low reset idles the sequencer, clears out_valid, sets upper_limit to 65535.
`default_nettype none

module aliquot_sum_classifier (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [asc_pkg::VALUE_WIDTH-1:0]     in_value,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [asc_pkg::COUNT_WIDTH-1:0]          out_divisor_count,
  output logic [asc_pkg::SUM_OUT_WIDTH-1:0]        out_divisor_sum,
  output logic                                     out_is_perfect,
  output logic                                     out_is_amicable,
  input  wire logic                                cfg_we,
  input  wire logic [asc_pkg::LIMIT_WIDTH-1:0]     cfg_wdata
);

  logic [asc_pkg::LIMIT_WIDTH-1:0]     limit_r;
  logic                                out_valid_r;
  logic [asc_pkg::COUNT_WIDTH-1:0]     out_count_r;
  logic [asc_pkg::SUM_OUT_WIDTH-1:0]   out_sum_r;
  logic                                out_perf_r;
  logic                                out_amic_r;

  asc_pkg::op_t                        op;
  asc_pkg::dp_status_t                 status;
  logic                                idle;
  logic                                out_busy;
  logic                                load_en;
  logic                                publish;

  logic [asc_pkg::COUNT_WIDTH-1:0]     dp_count;
  logic [asc_pkg::SUM_OUT_WIDTH-1:0]   dp_sum;
  logic                                dp_perf;
  logic                                dp_amic;

  assign in_ready = idle;
  assign load_en  = in_valid && idle;
  assign out_busy = out_valid_r && !out_ready;
  assign publish  = (op == asc_pkg::OP_PUBLISH);

  asc_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_busy (out_busy),
    .status   (status),
    .op       (op),
    .idle     (idle)
  );

  asc_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .load_en       (load_en),
    .in_value      (in_value),
    .upper_limit   (limit_r),
    .op            (op),
    .status        (status),
    .divisor_count (dp_count),
    .divisor_sum   (dp_sum),
    .is_perfect    (dp_perf),
    .is_amicable   (dp_amic)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= asc_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  // The sequencer only reaches the publish step once the output register is
  // free or being emptied at the same edge.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (publish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (publish) begin
      out_count_r <= dp_count;
      out_sum_r   <= dp_sum;
      out_perf_r  <= dp_perf;
      out_amic_r  <= dp_amic;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_divisor_count = out_count_r;
  assign out_divisor_sum   = out_sum_r;
  assign out_is_perfect    = out_perf_r;
  assign out_is_amicable   = out_amic_r;

endmodule

`default_nettype wire
